/* design/sel_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude unit
package sel_pkg;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int GRAD_W       = 10;   // one kernel half: up to 4 * 255
   localparam int SUM_W        = 11;   // |Gx| + |Gy|: up to 2040

   // Input item kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 16'd768;

   localparam logic [SUM_W-1:0] SAT_LIMIT = 11'd255;
   localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic    op;
      pix_type pixel;
   } req_payload_type;

   typedef struct packed {
      pix_type magnitude;
      logic    row_end;
      logic    frame_end;
   } rsp_payload_type;

   // One row of the kernel footprint
   typedef struct packed {
      pix_type left;
      pix_type centre;
      pix_type right;
   } pix_row_type;

   // Full 3x3 footprint, top row first
   typedef struct packed {
      pix_row_type top;
      pix_row_type mid;
      pix_row_type bot;
   } kernel_win_type;

endpackage

/* design/sel_line_store.sv */
`timescale 1ns / 1ps
// Line store: one write port, two registered read ports, write-first on a clash
module sel_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  sel_pkg::pix_type         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output sel_pkg::pix_type         rd_data_a,
   output sel_pkg::pix_type         rd_data_b
);
   import sel_pkg::*;

   pix_type line_mem [DEPTH];
   pix_type rd_a_ff;
   pix_type rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; a write to the same entry in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : line_mem[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : line_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* design/sel_grad.sv */
`timescale 1ns / 1ps
// Sobel Gx/Gy on one 3x3 footprint, L1 magnitude saturated to 8 bits
module sel_grad (
   input  sel_pkg::kernel_win_type win,
   output sel_pkg::pix_type        magnitude
);
   import sel_pkg::*;

   logic [GRAD_W-1:0] gx_pos;
   logic [GRAD_W-1:0] gx_neg;
   logic [GRAD_W-1:0] gy_pos;
   logic [GRAD_W-1:0] gy_neg;
   logic [GRAD_W-1:0] gx_abs;
   logic [GRAD_W-1:0] gy_abs;
   logic [SUM_W-1:0]  grad_sum;

   // Weighted column and row sums, 1-2-1
   always_comb begin
      gx_pos = {2'b00, win.top.right} + {1'b0, win.mid.right, 1'b0} + {2'b00, win.bot.right};
      gx_neg = {2'b00, win.top.left}  + {1'b0, win.mid.left, 1'b0}  + {2'b00, win.bot.left};
      gy_pos = {2'b00, win.top.left}  + {1'b0, win.top.centre, 1'b0} + {2'b00, win.top.right};
      gy_neg = {2'b00, win.bot.left}  + {1'b0, win.bot.centre, 1'b0} + {2'b00, win.bot.right};
   end

   // Absolute differences, sum and saturate
   always_comb begin
      gx_abs    = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
      gy_abs    = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
      grad_sum  = {1'b0, gx_abs} + {1'b0, gy_abs};
      magnitude = (grad_sum > SAT_LIMIT) ? PIX_MAX : grad_sum[PIX_W-1:0];
   end

endmodule

/* design/sobel_edge_magnitude_3x3_unit.sv */
`timescale 1ns / 1ps
// The kernel stage registers each accepted item; its results go to the result register once
// that has room, and a second result waits there behind the first. Throughput: one item per
// cycle while the receiver does not stall. A row's last pixel gives two results, but the next
// row's first pixel gives none, so rows stream with no gap; only a drain tick right after a
// frame's last pixel waits for the result register to have room. Reset (synchronous, active
// high) clears counters, pipeline and window; line stores are not cleared, only read once written.
module sobel_edge_magnitude_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sel_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sel_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_write,
   input  logic [sel_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sel_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sel_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   typedef struct packed {
      logic          op;
      pix_type       pixel;
      logic [AW-1:0] col;
      logic          row_ge1;
      logic          row_ge2;
      logic          col_ge1;
      logic          col_is1;
      logic          col_last;
      logic          width_one;
      logic          drain_first;
      logic          drain_last;
      logic          top_upper;
   } s1_type;

   // Last column index for a programmed width, clamped to 1..MAX_WIDTH
   function automatic logic [AW-1:0] width_last(input logic [WIDTH_REG_W-1:0] w);
      logic [AW-1:0] res;
      if (w == '0) begin
         res = '0;
      end else if (int'(w) > MAX_WIDTH) begin
         res = AW'(MAX_WIDTH - 1);
      end else begin
         res = AW'(w - 1'b1);
      end
      return res;
   endfunction

   // Configuration and frame position
   logic [AW-1:0]           width_last_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [AW-1:0]           col_ff,   col_in;
   logic [HEIGHT_REG_W-1:0] row_ff,   row_in;
   logic [AW-1:0]           drain_ff, drain_in;

   logic          frame_done;
   logic          drain_ok;
   logic [AW-1:0] pix_col;
   logic [HEIGHT_REG_W-1:0] pix_row;
   logic          req_xfer;
   logic          rsp_xfer;

   // Kernel stage
   logic    s1_valid_ff, s1_valid_in;
   s1_type  s1_ff, s1_in;
   logic    s1_load;
   logic    s1_fire;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;

   pix_type up_rd_a, up_rd_b, mid_rd_a, mid_rd_b;
   pix_type mid_val, top_val;
   pix_type top_centre, top_right, top_left, mid_left;
   pix_type prev_top_ff, prev_mid_ff;
   logic    line_wr;

   kernel_win_type win_ff, win_in;
   kernel_win_type res0_win, res1_win, drain_win, unit0_win;
   pix_type        mag0, mag1;
   logic           res0_v, res1_v;
   logic [1:0]     res_n;
   rsp_payload_type res_first, res_second;

   // Result register, up to two results
   logic [1:0]      out_cnt_ff, out_cnt_in;
   rsp_payload_type out0_ff, out0_in;
   rsp_payload_type out1_ff, out1_in;
   logic            out_free;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_fire;
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_data  = out0_ff;

   // Frame position of an incoming pixel; a finished frame restarts
   always_comb begin
      frame_done = (row_ff >= height_ff);
      drain_ok   = frame_done && (drain_ff <= width_last_ff);
      pix_col    = frame_done ? '0 : col_ff;
      pix_row    = frame_done ? '0 : row_ff;
   end

   // Counter next values
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (csr_write) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = '0;
      end else if (req_xfer) begin
         if (req_data.op == OP_PIXEL) begin
            drain_in = '0;
            if (pix_col == width_last_ff) begin
               col_in = '0;
               row_in = pix_row + 1'b1;
            end else begin
               col_in = pix_col + 1'b1;
               row_in = pix_row;
            end
         end else if (drain_ok) begin
            if (drain_ff == width_last_ff) begin
               col_in   = '0;
               row_in   = '0;
               drain_in = '0;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
      end
   end

   // Configuration registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff <= width_last(IMAGE_WIDTH_RESET);
         height_ff     <= IMAGE_HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         drain_ff      <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_last_ff <= width_last(csr_wdata[WIDTH_REG_W-1:0]);
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= (csr_wdata == '0) ? HEIGHT_REG_W'(1) : csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Kernel stage load; ignored drain ticks are dropped at the input
   always_comb begin
      s1_load = req_xfer && ((req_data.op == OP_PIXEL) || drain_ok);
      s1_valid_in = s1_load || (s1_valid_ff && !s1_fire);

      s1_in.op          = req_data.op;
      s1_in.pixel       = req_data.pixel;
      s1_in.col         = pix_col;
      s1_in.row_ge1     = (pix_row != '0);
      s1_in.row_ge2     = (pix_row > HEIGHT_REG_W'(1));
      s1_in.col_ge1     = (pix_col != '0);
      s1_in.col_is1     = (pix_col == AW'(1));
      s1_in.col_last    = (pix_col == width_last_ff);
      s1_in.width_one   = (width_last_ff == '0);
      s1_in.drain_first = (drain_ff == '0);
      s1_in.drain_last  = (drain_ff == width_last_ff);
      s1_in.top_upper   = (height_ff > HEIGHT_REG_W'(1));

      rd_addr_a = (req_data.op == OP_PIXEL) ? pix_col : drain_ff;
      rd_addr_b = (drain_ff == width_last_ff) ? drain_ff : (drain_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
   end

   // Line stores: row r-2 and row r-1
   assign line_wr = s1_fire && (s1_ff.op == OP_PIXEL);

   sel_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock     (clock),
      .wr_en     (line_wr),
      .wr_addr   (s1_ff.col),
      .wr_data   (mid_val),
      .rd_en     (s1_load),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (up_rd_a),
      .rd_data_b (up_rd_b)
   );

   sel_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock     (clock),
      .wr_en     (line_wr),
      .wr_addr   (s1_ff.col),
      .wr_data   (s1_ff.pixel),
      .rd_en     (s1_load),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (mid_rd_a),
      .rd_data_b (mid_rd_b)
   );

   // Pixel path: replicate rows at the top, shift the window
   always_comb begin
      mid_val = s1_ff.row_ge1 ? mid_rd_a : s1_ff.pixel;
      top_val = s1_ff.row_ge2 ? up_rd_a : mid_val;

      win_in.top = '{left: win_ff.top.centre, centre: win_ff.top.right, right: top_val};
      win_in.mid = '{left: win_ff.mid.centre, centre: win_ff.mid.right, right: mid_val};
      win_in.bot = '{left: win_ff.bot.centre, centre: win_ff.bot.right, right: s1_ff.pixel};

      // result one column back; left edge replicated at column 1
      res0_win.top.left   = s1_ff.col_is1 ? win_in.top.centre : win_in.top.left;
      res0_win.top.centre = win_in.top.centre;
      res0_win.top.right  = win_in.top.right;
      res0_win.mid.left   = s1_ff.col_is1 ? win_in.mid.centre : win_in.mid.left;
      res0_win.mid.centre = win_in.mid.centre;
      res0_win.mid.right  = win_in.mid.right;
      res0_win.bot.left   = s1_ff.col_is1 ? win_in.bot.centre : win_in.bot.left;
      res0_win.bot.centre = win_in.bot.centre;
      res0_win.bot.right  = win_in.bot.right;

      // last column of the row; right edge replicated
      res1_win.top.left   = s1_ff.width_one ? win_in.top.right : win_in.top.centre;
      res1_win.top.centre = win_in.top.right;
      res1_win.top.right  = win_in.top.right;
      res1_win.mid.left   = s1_ff.width_one ? win_in.mid.right : win_in.mid.centre;
      res1_win.mid.centre = win_in.mid.right;
      res1_win.mid.right  = win_in.mid.right;
      res1_win.bot.left   = s1_ff.width_one ? win_in.bot.right : win_in.bot.centre;
      res1_win.bot.centre = win_in.bot.right;
      res1_win.bot.right  = win_in.bot.right;
   end

   // Drain path: final row, bottom replicated; left column carried from last tick
   always_comb begin
      top_centre = s1_ff.top_upper ? up_rd_a : mid_rd_a;
      top_right  = s1_ff.top_upper ? up_rd_b : mid_rd_b;
      top_left   = s1_ff.drain_first ? top_centre : prev_top_ff;
      mid_left   = s1_ff.drain_first ? mid_rd_a : prev_mid_ff;

      drain_win.top = '{left: top_left, centre: top_centre, right: top_right};
      drain_win.mid = '{left: mid_left, centre: mid_rd_a, right: mid_rd_b};
      drain_win.bot = drain_win.mid;

      unit0_win = (s1_ff.op == OP_PIXEL) ? res0_win : drain_win;
   end

   sel_grad u_grad0 (
      .win       (unit0_win),
      .magnitude (mag0)
   );

   sel_grad u_grad1 (
      .win       (res1_win),
      .magnitude (mag1)
   );

   // Results of the item in the kernel stage
   always_comb begin
      if (s1_ff.op == OP_PIXEL) begin
         res0_v    = s1_ff.row_ge1 && s1_ff.col_ge1;
         res1_v    = s1_ff.row_ge1 && s1_ff.col_last;
         res_first = res0_v ? '{magnitude: mag0, row_end: 1'b0, frame_end: 1'b0}
                            : '{magnitude: mag1, row_end: 1'b1, frame_end: 1'b0};
      end else begin
         res0_v    = 1'b1;
         res1_v    = 1'b0;
         res_first = '{magnitude: mag0, row_end: s1_ff.drain_last,
                       frame_end: s1_ff.drain_last};
      end
      res_second = '{magnitude: mag1, row_end: 1'b1, frame_end: 1'b0};
      res_n      = {1'b0, res0_v} + {1'b0, res1_v};

      out_free = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_xfer);
      s1_fire  = s1_valid_ff && (out_free || (res_n == 2'd0));
   end

   // Window and drain carry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (line_wr) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && (s1_ff.op == OP_DRAIN)) begin
         prev_top_ff <= top_centre;
         prev_mid_ff <= mid_rd_a;
      end
   end

   // Result register next values
   always_comb begin
      out_cnt_in = out_cnt_ff;
      out0_in    = out0_ff;
      out1_in    = out1_ff;
      if (s1_fire && (res_n != 2'd0)) begin
         out_cnt_in = res_n;
         out0_in    = res_first;
         out1_in    = res_second;
      end else if (rsp_xfer) begin
         out_cnt_in = out_cnt_ff - 2'd1;
         out0_in    = out1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

endmodule

/* design/sel_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Sobel edge magnitude unit, bound to the top level
module sel_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input sel_pkg::rsp_payload_type        rsp_data
);
   import sel_pkg::*;

   // Input only backs up behind a waiting result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // The frame ends on the last pixel of a row
   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.frame_end || rsp_data.row_end))
      else $error("frame end without row end");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_3x3_unit sel_checker u_sel_checker (.*);

/* sim/sobel_edge_magnitude_3x3_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Sobel 3x3 edge magnitude unit
module sobel_edge_magnitude_3x3_unit_test;
   import sel_pkg::*;

   localparam int LINE_DEPTH    = 1024;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 200;
   localparam int RANDOM_ITEMS  = 200;
   localparam int WIDE_COLS     = 48;
   localparam int IDLE_MAX      = 18;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the block state
   pix_type                 upper_row [LINE_DEPTH];
   pix_type                 middle_row [LINE_DEPTH];
   pix_type                 window_px [9];   // row*3+col, col 2 newest
   int unsigned             next_col;
   int unsigned             next_row;
   int unsigned             drain_col;
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;

   rsp_payload_type expected_mags [$];
   int              error_count     = 0;
   int              cycle_count     = 0;
   int              effective_items = 0;
   int              req_gap_max     = 0;
   int              rsp_stall_max   = 0;
   bit              hold_request    = 1'b0;

   sobel_edge_magnitude_3x3_unit #(
      .MAX_WIDTH(LINE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Effective frame size: width clamps to 1..LINE_DEPTH, height zero acts as one
   function automatic int unsigned frame_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int unsigned frame_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic void restart_frame();
      next_col  = 0;
      next_row  = 0;
      drain_col = 0;
   endfunction

   // |Gx| + |Gy| of one footprint, saturated, queued as the next expected result
   function automatic void queue_gradient(input pix_type tl, tc, tr, ml, mc, mr,
                                          bl, bc, br, input logic row_last, frame_last);
      int              gx;
      int              gy;
      int              total;
      rsp_payload_type res;
      gx = (int'(tr) + 2 * int'(mr) + int'(br)) - (int'(tl) + 2 * int'(ml) + int'(bl));
      gy = (int'(tl) + 2 * int'(tc) + int'(tr)) - (int'(bl) + 2 * int'(bc) + int'(br));
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      total = gx + gy;
      res.magnitude = (total > int'(SAT_LIMIT)) ? PIX_MAX : pix_type'(total);
      res.row_end   = row_last;
      res.frame_end = frame_last;
      expected_mags.push_back(res);
   endfunction

   // Advance the predictor by one accepted item; returns 0 for an ignored drain
   function automatic bit compute_magnitudes(input req_payload_type item);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned d;
      int unsigned lft;
      int unsigned rgt;
      int          lc;
      pix_type     mid_px;
      pix_type     top_px;
      w = frame_width();
      h = frame_height();
      if (item.op == OP_PIXEL) begin
         // a pixel past the frame end starts a new frame
         if (next_row >= h || next_col >= w) restart_frame();
         c = next_col;
         r = next_row;
         mid_px = (r >= 1) ? middle_row[c] : item.pixel;
         top_px = (r >= 2) ? upper_row[c] : mid_px;
         for (int i = 0; i < 3; i++) begin
            window_px[i*3]   = window_px[i*3+1];
            window_px[i*3+1] = window_px[i*3+2];
         end
         window_px[2] = top_px;
         window_px[5] = mid_px;
         window_px[8] = item.pixel;
         upper_row[c]  = mid_px;
         middle_row[c] = item.pixel;
         if (r >= 1) begin
            // result one row up and one column left; left edge replicated
            if (c >= 1) begin
               lc = (c == 1) ? 1 : 0;
               queue_gradient(window_px[lc], window_px[1], window_px[2],
                              window_px[3+lc], window_px[4], window_px[5],
                              window_px[6+lc], window_px[7], window_px[8], 1'b0, 1'b0);
            end
            // last column of the row above, right edge replicated
            if (c == w - 1) begin
               lc = (w == 1) ? 2 : 1;
               queue_gradient(window_px[lc], window_px[2], window_px[2],
                              window_px[3+lc], window_px[5], window_px[5],
                              window_px[6+lc], window_px[8], window_px[8], 1'b1, 1'b0);
            end
         end
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         next_col = c;
         next_row = r;
         return 1'b1;
      end
      if (next_row >= h && drain_col < w) begin
         // final row: bottom replicates middle, single-row frames replicate top too
         d   = drain_col;
         lft = (d != 0) ? d - 1 : 0;
         rgt = (d + 1 < w) ? d + 1 : w - 1;
         if (h >= 2)
            queue_gradient(upper_row[lft], upper_row[d], upper_row[rgt],
                           middle_row[lft], middle_row[d], middle_row[rgt],
                           middle_row[lft], middle_row[d], middle_row[rgt],
                           d == w - 1, d == w - 1);
         else
            queue_gradient(middle_row[lft], middle_row[d], middle_row[rgt],
                           middle_row[lft], middle_row[d], middle_row[rgt],
                           middle_row[lft], middle_row[d], middle_row[rgt],
                           d == w - 1, d == w - 1);
         drain_col = d + 1;
         if (drain_col >= w) restart_frame();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // One input transfer, after a random gap; prediction at the accepting edge
   task automatic send_item(input logic op, input pix_type px);
      int              gap;
      req_payload_type item;
      item.op    = op;
      item.pixel = px;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (compute_magnitudes(item)) effective_items++;
   endtask

   // Pixel runs: 0 random, 1 black/white only, 2 slow ramp
   task automatic send_pixels(input int count, input int mode);
      pix_type px;
      px = pix_type'($urandom);
      for (int k = 0; k < count; k++) begin
         case (mode)
            0: px = pix_type'($urandom);
            1: px = ($urandom_range(0, 1) != 0) ? PIX_MAX : '0;
            default: px = px + pix_type'($urandom_range(0, 6)) - 8'd3;
         endcase
         send_item(OP_PIXEL, px);
      end
   endtask

   task automatic send_drains(input int count);
      repeat (count) send_item(OP_DRAIN, pix_type'($urandom));
   endtask

   // Drop valid, wait for every expected result, then let the pipeline empty
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_mags.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; only called while the block is idle
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
      else height_reg = value[HEIGHT_REG_W-1:0];
      restart_frame();
   endtask

   function automatic int idle_span();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return IDLE_MAX;
      endcase
   endfunction

   // Result sink: random stall per result, long hold-off on request
   initial begin : result_sink
      int n;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            n = HOLD_CYCLES;
         end else begin
            n = $urandom_range(0, rsp_stall_max);
         end
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid && !hold_request);
      end
   end

   // Compare every result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_payload_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_mags.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got mag %0d row_end %0b frame_end %0b",
                     $time, rsp_data.magnitude, rsp_data.row_end, rsp_data.frame_end);
         end else begin
            due = expected_mags.pop_front();
            if (rsp_data.magnitude !== due.magnitude) begin
               error_count++;
               $display("%0t: magnitude mismatch, expected %0d, got %0d",
                        $time, due.magnitude, rsp_data.magnitude);
            end
            if (rsp_data.row_end !== due.row_end) begin
               error_count++;
               $display("%0t: row_end mismatch, expected %0b, got %0b",
                        $time, due.row_end, rsp_data.row_end);
            end
            if (rsp_data.frame_end !== due.frame_end) begin
               error_count++;
               $display("%0t: frame_end mismatch, expected %0b, got %0b",
                        $time, due.frame_end, rsp_data.frame_end);
            end
         end
      end
   end

   // Drain ticks with no frame finished are dropped
   task automatic test_empty_drain();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      send_drains(2);
      wait_quiet();
   endtask

   // Register extremes: zero sizes, oversize width, tallest frame, single column
   task automatic test_register_extremes();
      req_gap_max   = 3;
      rsp_stall_max = 3;
      write_register(CSR_IMAGE_WIDTH, 16'd0);
      write_register(CSR_IMAGE_HEIGHT, 16'd0);
      send_item(OP_PIXEL, PIX_MAX);
      send_drains(2);
      wait_quiet();
      write_register(CSR_IMAGE_WIDTH, 16'hFFFF);
      write_register(CSR_IMAGE_HEIGHT, 16'hFFFF);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, PIX_MAX);
      wait_quiet();
      write_register(CSR_IMAGE_WIDTH, 16'd1);
      write_register(CSR_IMAGE_HEIGHT, 16'd3);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, PIX_MAX);
      send_item(OP_PIXEL, 8'h7F);
      send_drains(1);
      wait_quiet();
   endtask

   // Checkerboard saturates the sum; upper data bits of the width write are dropped
   task automatic test_saturation();
      req_gap_max   = 0;
      rsp_stall_max = 2;
      write_register(CSR_IMAGE_WIDTH, 16'hF803);
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, PIX_MAX);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, PIX_MAX);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, PIX_MAX);
      send_drains(4);
      wait_quiet();
   endtask

   // Pixels after a frame end, back-to-back frames, restart by a register write
   task automatic test_frame_restarts();
      req_gap_max   = 4;
      rsp_stall_max = 4;
      write_register(CSR_IMAGE_WIDTH, 16'd2);
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixels(4, 0);
      send_drains(1);
      send_pixels(4, 0);
      send_drains(2);
      send_pixels(3, 1);
      send_drains(1);
      wait_quiet();
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixels(4, 2);
      send_drains(2);
      wait_quiet();
   endtask

   // Long receiver hold-off while the sender streams, then the sender waits it out
   task automatic test_receiver_hold();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      write_register(CSR_IMAGE_WIDTH, 16'd4);
      write_register(CSR_IMAGE_HEIGHT, 16'd4);
      hold_request = 1'b1;
      send_pixels(16, 0);
      send_drains(4);
      wait_quiet();
   endtask

   // One frame wider than any of the random ones
   task automatic test_wide_frame();
      req_gap_max   = 2;
      rsp_stall_max = 2;
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(WIDE_COLS));
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixels(WIDE_COLS, 1);
      send_pixels(WIDE_COLS, 2);
      send_drains(WIDE_COLS);
      wait_quiet();
   endtask

   // Mostly whole frames of random small sizes, with noise and broken frames
   task automatic test_random_frames();
      int                    target;
      int unsigned           w;
      int unsigned           h;
      int unsigned           left;
      int                    pick;
      int                    mode;
      logic [CSR_DATA_W-1:0] size_val;
      target = effective_items + RANDOM_ITEMS;
      while (effective_items < target) begin
         req_gap_max   = idle_span();
         rsp_stall_max = idle_span();
         if ($urandom_range(0, 3) != 0) begin
            wait_quiet();
            pick = $urandom_range(0, 19);
            if (pick == 0) size_val = '0;
            else if (pick < 15) size_val = CSR_DATA_W'($urandom_range(1, 8));
            else size_val = CSR_DATA_W'($urandom_range(9, 40));
            write_register(CSR_IMAGE_WIDTH, size_val);
            write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(0, 5)));
         end
         w    = frame_width();
         h    = frame_height();
         left = (next_row >= h) ? w * h : w * h - next_row * w - next_col;
         mode = $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 8))
                  send_item(logic'($urandom_range(0, 1)), pix_type'($urandom));
            end
            1: send_pixels($urandom_range(1, left), mode);
            2: begin
               send_pixels(left, mode);
               send_drains($urandom_range(0, w - 1));
            end
            default: begin
               send_pixels(left, mode);
               send_drains(w + (($urandom_range(0, 3) == 0) ? 1 : 0));
            end
         endcase
      end
      wait_quiet();
   endtask

   initial begin
      for (int i = 0; i < 9; i++) window_px[i] = '0;
      restart_frame();
      width_reg  = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_empty_drain();
      test_register_extremes();
      test_saturation();
      test_frame_restarts();
      test_receiver_hold();
      test_wide_frame();
      test_random_frames();

      wait_quiet();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
